[rtl/dc_motor_power_linearizer_macros.svh]
// assertion macros for the motor power linearizer
`ifndef DC_MOTOR_POWER_LINEARIZER_MACROS_SVH
`define DC_MOTOR_POWER_LINEARIZER_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (prop)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (prop)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rstn, cond, prop)
`define ASSERT_NEXT(label, clk, rstn, cond, prop)
`endif

`endif

[rtl/dcmpl_pkg.sv]
`timescale 1ns / 1ps

package dcmpl_pkg;

    localparam int TABLE_LEN  = 11;
    localparam int SEG_W      = 4;
    localparam int RPM_W      = 10;
    localparam int POWER_W    = 7;
    localparam int PE_W       = 4;
    localparam int DEN_W      = 8;
    localparam int NUM_W      = 15;
    localparam int PROD_W     = 19;
    localparam int DIVIDEND_W = 26;
    localparam int DIVISOR_W  = 18;
    localparam int DUTY_W     = 8;
    localparam int CNT_W      = $clog2(DUTY_W);

    localparam logic [POWER_W-1:0] INIT_POWER = 7'd30;
    localparam logic [POWER_W-1:0] POWER_MAX  = 7'd100;
    localparam logic [POWER_W-1:0] POWER_KNEE = 7'd10;
    localparam logic [RPM_W-1:0]   RPM_BASE   = 10'd250;
    localparam logic [SEG_W-1:0]   SEG_FIRST  = 4'd1;
    localparam logic [SEG_W-1:0]   SEG_LAST   = 4'd10;
    localparam logic [DUTY_W-1:0]  PWM_FULL   = 8'd255;
    localparam logic [DIVISOR_W-1:0] DEN_SCALE = 18'd1000;

    typedef logic [RPM_W-1:0] rpm_t;

    // rpm in tenths at powers 0, 10, ..., 100
    localparam rpm_t FWD_RPM10 [TABLE_LEN] = '{
        10'd0, 10'd0, 10'd0, 10'd225, 10'd354, 10'd457,
        10'd582, 10'd658, 10'd682, 10'd697, 10'd712
    };
    localparam rpm_t REV_RPM10 [TABLE_LEN] = '{
        10'd0, 10'd0, 10'd38, 10'd83, 10'd152, 10'd192,
        10'd299, 10'd486, 10'd585, 10'd655, 10'd713
    };

    typedef enum logic [1:0] {
        OP_SET_POWER = 2'd0,
        OP_SET_MODE  = 2'd1,
        OP_REINIT    = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        MODE_NORMAL  = 2'd0,
        MODE_REVERSE = 2'd1,
        MODE_COAST   = 2'd2,
        MODE_BRAKE   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_NUM,
        ST_PROD,
        ST_DIVGO,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [7:0]  motor_index;
        logic signed [15:0] command_value;
    } in_item_t;

    typedef struct packed {
        logic              motor_id;
        logic              direction_pin;
        logic [DUTY_W-1:0] pwm_duty;
    } out_item_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    function automatic rpm_t rpm_entry(input logic rev, input logic [SEG_W-1:0] idx);
        rpm_t val;
        val = '0;
        if (idx < SEG_W'(TABLE_LEN)) begin
            val = rev ? REV_RPM10[idx] : FWD_RPM10[idx];
        end
        return val;
    endfunction

endpackage

[rtl/dcmpl_div.sv]
`timescale 1ns / 1ps

module dcmpl_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [dcmpl_pkg::DIVIDEND_W-1:0]  dividend,
    input  logic [dcmpl_pkg::DIVISOR_W-1:0]   divisor,
    output logic [dcmpl_pkg::DUTY_W-1:0]      quotient,
    output dcmpl_pkg::div_status_t            status
);
    import dcmpl_pkg::*;

    logic [DIVIDEND_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg;
    logic [DUTY_W-1:0]     quo_reg, quo_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg, done_reg;
    logic [DIVIDEND_W-1:0] trial;
    logic                  fits;

    // one restoring step per cycle, msb first
    always_comb begin
        trial    = DIVIDEND_W'(dvs_reg) << cnt_reg;
        fits     = rem_reg >= trial;
        rem_next = fits ? rem_reg - trial : rem_reg;
        quo_next = quo_reg;
        quo_next[cnt_reg] = fits;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DUTY_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend;
            dvs_reg <= divisor;
            quo_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

[rtl/dc_motor_power_linearizer.sv]
// sequence: coast, brake and zero power go from the input state straight to the output state;
// otherwise a table walk of one segment per cycle (4 to 10 here) comes first,
// then three setup states and an 8-step restoring divider shared by all items
// throughput: one item at a time; the next input is taken once the result is loaded
// reset: synchronous active-low aresetn; every motor returns to coast at power 30
`timescale 1ns / 1ps
`include "dc_motor_power_linearizer_macros.svh"

module dc_motor_power_linearizer #(
    parameter int MOTOR_COUNT = 2
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  dcmpl_pkg::in_item_t   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output dcmpl_pkg::out_item_t  m_data
);
    import dcmpl_pkg::*;

    localparam int IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

    state_t state_reg, state_next;

    logic [POWER_W-1:0] power_reg [MOTOR_COUNT];
    mode_t              mode_reg  [MOTOR_COUNT];

    logic [IDX_W-1:0]   idx_reg;
    mode_t              md_reg;
    logic [RPM_W-1:0]   r_reg;
    logic [PE_W-1:0]    pe_reg;
    logic [SEG_W-1:0]   seg_reg;
    logic [RPM_W-1:0]   lo_reg;
    logic [DEN_W-1:0]   d_reg;
    logic               found_reg;
    logic [NUM_W-1:0]   num_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic               dir_reg;
    logic [DUTY_W-1:0]  duty_reg;
    logic               out_valid_reg;
    out_item_t          out_data_reg;

    logic               accept;
    logic               idx_ok, mode_ok, op_ok, item_ok;
    logic [IDX_W-1:0]   idx;
    logic [POWER_W-1:0] clamp_pw, new_pw;
    mode_t              new_md;
    logic               special;
    logic [DUTY_W-1:0]  special_duty;
    logic [RPM_W-1:0]   new_r;
    logic               rev_sel;
    rpm_t               lo, hi;
    logic               hit;
    logic [16:0]        num_wide;
    logic [SEG_W-1:0]   seg_m1;
    logic               out_free;
    logic               div_start;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [DIVISOR_W-1:0]  div_divisor;
    logic [DUTY_W-1:0]  div_quo;
    div_status_t        div_stat;

    // input decode
    always_comb begin
        accept  = s_valid && s_ready;
        idx_ok  = !s_data.motor_index[7] && (s_data.motor_index[6:0] < 7'(MOTOR_COUNT));
        mode_ok = !s_data.command_value[15] && (s_data.command_value[14:2] == '0);
        idx     = s_data.motor_index[IDX_W-1:0];
        if (s_data.command_value[15]) begin
            clamp_pw = '0;
        end else if (s_data.command_value > 16'sd100) begin
            clamp_pw = POWER_MAX;
        end else begin
            clamp_pw = s_data.command_value[POWER_W-1:0];
        end
        new_pw = power_reg[idx];
        new_md = mode_reg[idx];
        op_ok  = 1'b0;
        unique case (s_data.opcode)
            OP_SET_POWER: begin
                op_ok  = 1'b1;
                new_pw = clamp_pw;
            end
            OP_SET_MODE: begin
                op_ok  = mode_ok;
                new_md = mode_t'(s_data.command_value[1:0]);
            end
            OP_REINIT: begin
                op_ok  = 1'b1;
                new_pw = INIT_POWER;
                new_md = MODE_COAST;
            end
            default: op_ok = 1'b0;
        endcase
        item_ok = idx_ok && op_ok;
        special = (new_md == MODE_COAST) || (new_md == MODE_BRAKE) || (new_pw == '0);
        special_duty = ((new_md == MODE_BRAKE) || (new_md == MODE_REVERSE)) ? PWM_FULL : '0;
        if (new_pw >= POWER_KNEE) begin
            new_r = RPM_BASE + RPM_W'(new_pw - POWER_KNEE) * RPM_W'(5);
        end else begin
            new_r = RPM_BASE;
        end
    end

    // table walk, numerator terms and divider operands
    always_comb begin
        rev_sel  = (md_reg == MODE_REVERSE);
        seg_m1   = seg_reg - SEG_W'(1);
        lo       = rpm_entry(rev_sel, seg_m1);
        hi       = rpm_entry(rev_sel, seg_reg);
        hit      = (lo <= r_reg) && (r_reg <= hi);
        num_wide = 17'(r_reg - lo_reg) * 17'd10 + 17'(seg_m1) * 17'(d_reg) * 17'd10;
        div_dividend = (DIVIDEND_W'(prod_reg) << 8) - DIVIDEND_W'(prod_reg);
        div_divisor  = DIVISOR_W'(den_reg) * DEN_SCALE;
        out_free     = !out_valid_reg || m_ready;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && item_ok) begin
                    state_next = special ? ST_OUT : ST_WALK;
                end
            end
            ST_WALK: begin
                if (hit || seg_reg == SEG_LAST) begin
                    state_next = ST_NUM;
                end
            end
            ST_NUM:   state_next = ST_PROD;
            ST_PROD:  state_next = ST_DIVGO;
            ST_DIVGO: state_next = ST_DIV;
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready   = 1'b0;
        div_start = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_ready   = 1'b1;
            ST_DIVGO: div_start = 1'b1;
            default: begin
                s_ready   = 1'b0;
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MOTOR_COUNT; i++) begin
                power_reg[i] <= INIT_POWER;
                mode_reg[i]  <= MODE_COAST;
            end
        end else begin
            state_reg <= state_next;
            if (accept && item_ok) begin
                power_reg[idx] <= new_pw;
                mode_reg[idx]  <= new_md;
            end
            if (state_reg == ST_OUT && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && item_ok) begin
            idx_reg  <= idx;
            md_reg   <= new_md;
            r_reg    <= new_r;
            pe_reg   <= (new_pw < POWER_KNEE) ? PE_W'(new_pw) : PE_W'(POWER_KNEE);
            seg_reg  <= SEG_FIRST;
            dir_reg  <= (new_md == MODE_REVERSE) || (new_md == MODE_BRAKE);
            duty_reg <= special_duty;
        end
        if (state_reg == ST_WALK) begin
            found_reg <= hit;
            lo_reg    <= lo;
            d_reg     <= DEN_W'(hi - lo);
            if (!hit) begin
                seg_reg <= seg_reg + SEG_W'(1);
            end
        end
        if (state_reg == ST_NUM) begin
            if (!found_reg) begin
                num_reg <= '0;
                den_reg <= DEN_W'(1);
            end else if (d_reg == '0) begin
                num_reg <= NUM_W'(seg_m1) * NUM_W'(10);
                den_reg <= DEN_W'(1);
            end else begin
                num_reg <= num_wide[NUM_W-1:0];
                den_reg <= d_reg;
            end
        end
        if (state_reg == ST_PROD) begin
            prod_reg <= PROD_W'(num_reg) * PROD_W'(pe_reg);
        end
        if (state_reg == ST_DIV && div_stat.done) begin
            duty_reg <= (md_reg == MODE_REVERSE) ? PWM_FULL - div_quo : div_quo;
        end
        if (state_reg == ST_OUT && out_free) begin
            out_data_reg.motor_id      <= idx_reg[0];
            out_data_reg.direction_pin <= dir_reg;
            out_data_reg.pwm_duty      <= duty_reg;
        end
    end

    dcmpl_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quo),
        .status   (div_stat)
    );

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    `ASSERT_IMPLY(a_div_done_in_div, aclk, aresetn, div_stat.done, state_reg == ST_DIV)
    `ASSERT_NEXT(a_bad_item_dropped, aclk, aresetn, accept && !item_ok, state_reg == ST_IDLE)
    `ASSERT_IMPLY(a_seg_range, aclk, aresetn, state_reg == ST_WALK, seg_reg >= SEG_FIRST && seg_reg <= SEG_LAST)
    `ASSERT_IMPLY(a_div_busy_in_div, aclk, aresetn, div_stat.busy, state_reg == ST_DIV)

endmodule
